FILE: rtl/core/hts_pkg.sv
// Package with the shared types and character constants of the HTML tag stripper.
package hts_pkg;

    localparam int HTS_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_P_LO  = 8'h70;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_R_UP  = 8'h52;

    typedef enum logic [2:0] {
        ST_TEXT   = 3'd0,
        ST_TAG    = 3'd1,
        ST_TAG_P  = 3'd2,
        ST_TAG_B  = 3'd3,
        ST_TAG_BR = 3'd4,
        ST_NL_RUN = 3'd5,
        ST_SP_RUN = 3'd6
    } t_parse_state;

    // One queued command: one or two output bytes.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/core/hts_if.sv
// Stream interfaces for the input bytes and the output text bytes.
interface hts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_end;

    modport source (output valid, output in_byte, output frame_end, input ready);
    modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

interface hts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: rtl/core/hts_front.sv
// Front end: parses each input byte and queues the text bytes it produces.
module hts_front
    import hts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_frame_end,
    input  t_q_status  i_q_status,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_parse_state text_next;
    t_parse_state tag_next;

    logic is_lt, is_gt, is_nl, is_cr, is_sp, is_p, is_b, is_r;
    logic text_emit;
    logic accept;
    logic has_result;

    assign is_lt = (i_byte == CH_LT);
    assign is_gt = (i_byte == CH_GT);
    assign is_nl = (i_byte == CH_NL);
    assign is_cr = (i_byte == CH_CR);
    assign is_sp = (i_byte == CH_SP);
    assign is_p  = (i_byte == CH_P_LO) || (i_byte == CH_P_UP);
    assign is_b  = (i_byte == CH_B_LO) || (i_byte == CH_B_UP);
    assign is_r  = (i_byte == CH_R_LO) || (i_byte == CH_R_UP);

    assign text_emit = !(is_lt || is_nl || is_sp || is_gt || is_cr);

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && has_result;

    always_comb begin
        if (is_lt) begin
            text_next = ST_TAG;
        end else if (is_nl) begin
            text_next = ST_NL_RUN;
        end else if (is_sp) begin
            text_next = ST_SP_RUN;
        end else begin
            text_next = ST_TEXT;
        end

        if (is_p) begin
            tag_next = ST_TAG_P;
        end else if (is_b) begin
            tag_next = ST_TAG_B;
        end else if (is_gt) begin
            tag_next = ST_TEXT;
        end else begin
            tag_next = ST_TAG;
        end
    end

    // Next state.
    always_comb begin
        case (r_state)
            ST_NL_RUN: n_state = is_nl ? ST_NL_RUN : text_next;
            ST_SP_RUN: n_state = is_sp ? ST_SP_RUN : text_next;
            ST_TAG_P:  n_state = tag_next;
            ST_TAG_BR: n_state = tag_next;
            ST_TAG:    n_state = tag_next;
            ST_TAG_B: begin
                if (is_r) begin
                    n_state = ST_TAG_BR;
                end else if (is_gt) begin
                    n_state = ST_TEXT;
                end else begin
                    n_state = ST_TAG;
                end
            end
            default:   n_state = text_next;
        endcase
        if (i_frame_end) begin
            n_state = ST_TEXT;
        end
    end

    // Outputs: the bytes this input produces.
    always_comb begin
        has_result  = 1'b0;
        o_cmd.byte0 = i_byte;
        o_cmd.byte1 = i_byte;
        o_cmd.two   = 1'b0;
        case (r_state)
            ST_NL_RUN: begin
                if (!is_nl) begin
                    has_result  = 1'b1;
                    o_cmd.byte0 = CH_SP;
                    o_cmd.two   = text_emit;
                end
            end
            ST_SP_RUN: begin
                if (!is_sp) begin
                    has_result  = 1'b1;
                    o_cmd.byte0 = CH_SP;
                    o_cmd.two   = text_emit;
                end
            end
            ST_TAG_P: begin
                if (is_gt) begin
                    has_result  = 1'b1;
                    o_cmd.byte0 = CH_NL;
                    o_cmd.byte1 = CH_NL;
                    o_cmd.two   = 1'b1;
                end
            end
            ST_TAG_BR: begin
                if (is_gt) begin
                    has_result  = 1'b1;
                    o_cmd.byte0 = CH_NL;
                end
            end
            ST_TAG, ST_TAG_B: begin
                has_result = 1'b0;
            end
            default: begin
                has_result = text_emit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TEXT;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/hts_queue.sv
// Small command queue between the parser front end and the output back end.
module hts_queue
    import hts_pkg::*;
#(
    parameter int DEPTH = HTS_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [IW-1:0] r_wr;
    logic [IW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == FULL_CNT);
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/hts_back.sv
// Back end: turns queued commands into output beats, one byte per beat.
module hts_back
    import hts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_q_status,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_phase;
    logic       n_valid;
    logic [7:0] n_byte;
    logic       n_last;
    logic       n_phase;
    logic       load;

    assign load    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    // The head entry stays in the queue until its last byte is loaded.
    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_phase = r_phase;
        o_pop   = 1'b0;
        if (load) begin
            if (r_phase) begin
                n_valid = 1'b1;
                n_byte  = i_head.byte1;
                n_last  = 1'b1;
                n_phase = 1'b0;
                o_pop   = 1'b1;
            end else if (!i_q_status.empty) begin
                n_valid = 1'b1;
                n_byte  = i_head.byte0;
                n_last  = !i_head.two;
                n_phase = i_head.two;
                o_pop   = !i_head.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule

FILE: rtl/core/html_tag_stripper.sv
// Top level of the HTML tag stripper: parser front end, command queue, output back end.
//
//   channel   direction  beat payload              notes
//   i_in      input      in_byte[7:0], frame_end   one HTML byte per beat
//   o_out     output     out_byte[7:0], run_last   one text byte per beat
//
// One input beat is taken per cycle while the command queue has room.
// An input byte yields zero, one or two output beats; the output register sends one
// byte per cycle while o_out.ready is high, so a two-byte result holds the back end
// for both bytes. Results pass through the command queue into the output register.
// Reset is synchronous and active low; no clearing pass is needed.
// The front end stalls only when the queue is full; the back end stalls on o_out.ready.
module html_tag_stripper
    import hts_pkg::*;
#(
    parameter int QUEUE_DEPTH = HTS_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hts_in_if.sink    i_in,
    hts_out_if.source o_out
);

    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    hts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_byte      (i_in.in_byte),
        .i_frame_end (i_in.frame_end),
        .i_q_status  (q_status),
        .o_ready     (i_in.ready),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    hts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    hts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_q_status (q_status),
        .i_ready    (o_out.ready),
        .o_pop      (pop),
        .o_valid    (o_out.valid),
        .o_byte     (o_out.out_byte),
        .o_last     (o_out.run_last)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.run_last) |=> o_out.valid)
        else $error("second byte of a pair did not follow the first");

endmodule
